// ===== hdl/midi_meta_event_parser_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MIDI_META_EVENT_PARSER_CORE_DEFINES_SVH
`define MIDI_META_EVENT_PARSER_CORE_DEFINES_SVH

// An implication that is checked at every rising clock edge while out of reset.
`define MMEP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A check that is sampled on the parser clock and reset.
`define MMEP_ASSERT(lbl, prop, msg) \
    `MMEP_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== hdl/mmep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI meta event parser package
// Parse phases, event codes and the descriptor passed from front to back end.
// ----------------------------------------------------------------------------
package mmep_pkg;

    typedef enum logic [4:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_METATYPE, PH_FIXLEN,
        PH_TEMPO0, PH_TEMPO1, PH_TEMPO2, PH_TS_NUM, PH_TS_EXP, PH_TS_MET,
        PH_TS_32, PH_SKIPLEN, PH_SKIP, PH_TEXTLEN, PH_TEXT1, PH_TEXT2
    } t_phase;

    localparam logic [7:0] EV_END      = 8'hFF;
    localparam logic [7:0] EV_TEMPO    = 8'd25;
    localparam logic [7:0] EV_TIMESIG  = 8'd24;
    localparam logic [7:0] EV_LOOP_BEG = 8'd20;
    localparam logic [7:0] EV_LOOP_MID = 8'd19;
    localparam logic [7:0] EV_LOOP_END = 8'd18;
    localparam logic [7:0] EV_LOOP_CNT = 8'd17;
    localparam logic [7:0] EV_NONE     = 8'd0;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_STATUS  = 2'd1;
    localparam logic [1:0] ERR_TIMESIG = 2'd2;

    localparam logic [7:0] ST_RESET    = 8'h80;
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [3:0] ST_PROG_HI  = 4'hC;
    localparam logic [3:0] ST_PRES_HI  = 4'hD;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] CH_OPEN     = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE    = 8'h5D;  // ']'
    localparam logic [7:0] CH_COLON    = 8'h3A;  // ':'

    localparam int TICK_W = 20;

    // For time signatures value holds the exponent above the numerator.
    typedef struct packed {
        logic [31:0] ev_time;
        logic [7:0]  ev_type;
        logic [23:0] value;
        logic [1:0]  err;
        logic        is_ts;
        logic        is_marker;
    } t_evt_desc;

endpackage

// ===== hdl/midi_meta_event_parser_core.sv =====
// One byte is accepted per cycle; the input stalls only when the four-entry queue is full.
// Each event passes through the queue, a back-end stage register and the output register.
// Results can leave one per cycle while the output side is ready.
// Reset is synchronous and active low; it clears parse state, the queue and the
// output, sets clocks_per_beat to 1 and zeroes the loop block count.
// ----------------------------------------------------------------------------
// MIDI meta event parser core
// Parses track bytes into end of track, tempo, time signature, loop and status error events.
// ----------------------------------------------------------------------------
module midi_meta_event_parser_core import mmep_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,     // clocks_per_beat
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  logic        i_s_axis_tuser,  // [0] track_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] event_time, [39:32] event_kind, [47:40] block_number,
    // [71:48] event_value, [73:72] error_code, [79:74] zero
    output logic [79:0] o_m_axis_tdata
);

    logic      accept, push, full, empty, pop;
    t_evt_desc push_desc, head_desc;

    assign o_s_axis_tready = !full;
    assign accept = i_s_axis_tvalid && !full;

    mmep_front u_front (
        .i_clk, .i_rst_n,
        .i_accept      (accept),
        .i_byte        (i_s_axis_tdata),
        .i_track_start (i_s_axis_tuser),
        .o_push        (push),
        .o_desc        (push_desc)
    );

    mmep_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_desc  (head_desc)
    );

    mmep_back u_back (
        .i_clk, .i_rst_n,
        .i_cfg_we,
        .i_cfg_wdata,
        .i_q_empty (empty),
        .i_q_desc  (head_desc),
        .o_q_pop   (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata)
    );

endmodule

// ===== hdl/mmep_front.sv =====
// ----------------------------------------------------------------------------
// MIDI meta event parser front end
// Walks the track byte by byte and queues a descriptor for each event found.
// ----------------------------------------------------------------------------
module mmep_front import mmep_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic [7:0] i_byte,
    input  logic      i_track_start,
    output logic      o_push,
    output t_evt_desc o_desc
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_time, n_time;
    logic [7:0]  r_status, n_status;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_skip, n_skip;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_mid, n_mid;
    logic [7:0]  r_num, n_num;
    logic [7:0]  r_exp, n_exp;
    logic        r_halt, n_halt;

    t_phase      e_phase;
    logic [31:0] e_time, e_acc, e_skip, acc_sh, skip_dec;
    logic [7:0]  e_status;
    logic        e_halt, vlq_last, two_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DELTA;
            r_time   <= '0;
            r_status <= ST_RESET;
            r_acc    <= '0;
            r_skip   <= '0;
            r_halt   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_time   <= n_time;
            r_status <= n_status;
            r_acc    <= n_acc;
            r_skip   <= n_skip;
            r_halt   <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_lo   <= n_lo;
        r_mid  <= n_mid;
        r_num  <= n_num;
        r_exp  <= n_exp;
    end

    always_comb begin
        e_phase  = i_track_start ? PH_DELTA : r_phase;
        e_time   = i_track_start ? 32'd0 : r_time;
        e_status = i_track_start ? ST_RESET : r_status;
        e_acc    = i_track_start ? 32'd0 : r_acc;
        e_skip   = i_track_start ? 32'd0 : r_skip;
        e_halt   = i_track_start ? 1'b0 : r_halt;
        acc_sh   = {e_acc[24:0], i_byte[6:0]};
        vlq_last = !i_byte[7];
        skip_dec = e_skip - 32'd1;
        two_data = !(e_status[7:4] == ST_PROG_HI || e_status[7:4] == ST_PRES_HI);

        n_phase  = r_phase;
        n_time   = r_time;
        n_status = r_status;
        n_acc    = r_acc;
        n_skip   = r_skip;
        n_halt   = r_halt;
        n_kind   = r_kind;
        n_lo     = r_lo;
        n_mid    = r_mid;
        n_num    = r_num;
        n_exp    = r_exp;
        o_push   = 1'b0;
        o_desc   = '0;

        if (i_accept) begin
            n_phase  = e_phase;
            n_time   = e_time;
            n_status = e_status;
            n_acc    = e_acc;
            n_skip   = e_skip;
            n_halt   = e_halt;
            o_desc.ev_time = e_time;
            if (!e_halt) begin
                unique case (e_phase)
                    PH_DELTA: begin
                        n_acc = acc_sh;
                        if (vlq_last) begin
                            n_time  = e_time + acc_sh;
                            n_acc   = '0;
                            n_phase = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        priority if (!i_byte[7]) begin
                            n_phase = two_data ? PH_DATA2 : PH_DELTA;
                        end else if (i_byte < ST_SYSEX) begin
                            n_status = i_byte;
                            n_phase  = PH_DATA1;
                        end else if (i_byte == ST_SYSEX || i_byte == ST_SYSEX_ESC) begin
                            n_phase = PH_SKIPLEN;
                        end else if (i_byte == ST_META) begin
                            n_phase = PH_METATYPE;
                        end else begin
                            n_halt  = 1'b1;
                            n_phase = PH_DELTA;
                            o_push  = 1'b1;
                            o_desc.ev_type = EV_NONE;
                            o_desc.err     = ERR_STATUS;
                        end
                    end
                    PH_DATA1: n_phase = two_data ? PH_DATA2 : PH_DELTA;
                    PH_DATA2: n_phase = PH_DELTA;
                    PH_METATYPE: begin
                        n_kind = i_byte;
                        if (i_byte != 8'd0 && i_byte[7:4] == 4'd0) begin
                            n_phase = PH_TEXTLEN;
                        end else if (i_byte == META_EOT || i_byte == META_TEMPO
                                     || i_byte == META_TIMESIG) begin
                            n_phase = PH_FIXLEN;
                        end else begin
                            n_phase = PH_SKIPLEN;
                        end
                    end
                    PH_FIXLEN: begin
                        if (r_kind == META_EOT) begin
                            n_phase = PH_DELTA;
                            o_push  = 1'b1;
                            o_desc.ev_type = EV_END;
                        end else begin
                            n_phase = (r_kind == META_TEMPO) ? PH_TEMPO0 : PH_TS_NUM;
                        end
                    end
                    PH_TEMPO0: begin
                        n_lo    = i_byte;
                        n_phase = PH_TEMPO1;
                    end
                    PH_TEMPO1: begin
                        n_mid   = i_byte;
                        n_phase = PH_TEMPO2;
                    end
                    PH_TEMPO2: begin
                        n_phase = PH_DELTA;
                        o_push  = 1'b1;
                        o_desc.ev_type = EV_TEMPO;
                        o_desc.value   = {i_byte, r_mid, r_lo};
                    end
                    PH_TS_NUM: begin
                        n_num   = i_byte;
                        n_phase = PH_TS_EXP;
                    end
                    PH_TS_EXP: begin
                        n_exp   = i_byte;
                        n_phase = PH_TS_MET;
                    end
                    PH_TS_MET: n_phase = PH_TS_32;
                    PH_TS_32: begin
                        n_phase = PH_DELTA;
                        o_push  = 1'b1;
                        o_desc.ev_type = EV_TIMESIG;
                        o_desc.value   = {8'd0, r_exp, r_num};
                        o_desc.is_ts   = 1'b1;
                    end
                    PH_SKIPLEN, PH_TEXTLEN: begin
                        n_acc = acc_sh;
                        if (vlq_last) begin
                            n_skip = acc_sh;
                            n_acc  = '0;
                            if (acc_sh == 32'd0) begin
                                n_phase = PH_DELTA;
                            end else begin
                                n_phase = (e_phase == PH_TEXTLEN) ? PH_TEXT1 : PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip  = skip_dec;
                        if (skip_dec == 32'd0) n_phase = PH_DELTA;
                    end
                    PH_TEXT1: begin
                        n_skip  = skip_dec;
                        n_phase = (skip_dec == 32'd0) ? PH_DELTA : PH_SKIP;
                        if (i_byte == CH_OPEN || i_byte == CH_COLON) begin
                            o_push = 1'b1;
                            o_desc.is_marker = 1'b1;
                            o_desc.ev_type = (i_byte == CH_OPEN) ? EV_LOOP_BEG : EV_LOOP_CNT;
                        end else if (i_byte == CH_CLOSE) begin
                            if (skip_dec == 32'd0) begin
                                o_push = 1'b1;
                                o_desc.is_marker = 1'b1;
                                o_desc.ev_type = EV_LOOP_END;
                            end else begin
                                n_phase = PH_TEXT2;
                            end
                        end
                    end
                    PH_TEXT2: begin
                        n_skip  = skip_dec;
                        n_phase = (skip_dec == 32'd0) ? PH_DELTA : PH_SKIP;
                        o_push  = 1'b1;
                        o_desc.is_marker = 1'b1;
                        o_desc.ev_type = (i_byte == CH_OPEN) ? EV_LOOP_MID : EV_LOOP_END;
                    end
                    default: n_phase = PH_DELTA;
                endcase
            end
        end
    end

endmodule

// ===== hdl/mmep_queue.sv =====
// ----------------------------------------------------------------------------
// MIDI meta event parser descriptor queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module mmep_queue import mmep_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_evt_desc i_desc,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_evt_desc o_desc
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_evt_desc          r_mem [DEPTH];
    logic [AW-1:0]      r_wptr, r_rptr;
    logic [AW:0]        r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= (r_wptr == AW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            if (i_pop)  r_rptr <= (r_rptr == AW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

// ===== hdl/mmep_back.sv =====
// ----------------------------------------------------------------------------
// MIDI meta event parser back end
// Computes time signature ticks, numbers loop markers and holds the result.
// ----------------------------------------------------------------------------
module mmep_back import mmep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       i_q_empty,
    input  t_evt_desc  i_q_desc,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [79:0] o_data
);

    logic [4:0]        r_cpb;
    logic              r_a_valid, r_o_valid;
    t_evt_desc         r_a_desc;
    logic [TICK_W-1:0] r_ticks;
    logic [7:0]        r_blk;
    logic [31:0]       r_o_time;
    logic [7:0]        r_o_type, r_o_blk;
    logic [23:0]       r_o_value;
    logic [1:0]        r_o_err;

    logic              out_adv, a_adv;
    logic [12:0]       num_cpb;
    logic [TICK_W-1:0] ticks, quot, rem, lowmask;
    logic [7:0]        expo;
    logic              ts_bad;

    assign out_adv = !r_o_valid || i_ready;
    assign a_adv   = !r_a_valid || out_adv;
    assign o_q_pop = a_adv && !i_q_empty;
    assign o_valid = r_o_valid;
    assign o_data  = {6'd0, r_o_err, r_o_value, r_o_blk, r_o_type, r_o_time};

    // 96 * n = 64 * n + 32 * n.
    assign num_cpb = {5'd0, i_q_desc.value[7:0]} * {8'd0, r_cpb};
    assign ticks = {1'b0, num_cpb, 6'd0} + {2'd0, num_cpb, 5'd0};

    always_comb begin
        expo    = r_a_desc.value[15:8];
        lowmask = ~({TICK_W{1'b1}} << expo[4:0]);
        if (expo[7:5] == 3'd0) begin
            quot = r_ticks >> expo[4:0];
            rem  = r_ticks & lowmask;
        end else begin
            quot = '0;
            rem  = r_ticks;
        end
        ts_bad = (rem != '0) || (quot == '0) || (quot[TICK_W-1:16] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpb     <= 5'd1;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_blk     <= '0;
        end else begin
            if (i_cfg_we) r_cpb <= i_cfg_wdata;
            if (a_adv) r_a_valid <= !i_q_empty;
            if (out_adv) begin
                r_o_valid <= r_a_valid;
                if (r_a_valid && r_a_desc.is_marker) r_blk <= r_blk + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_a_desc <= i_q_desc;
            r_ticks  <= ticks;
        end
        if (out_adv) begin
            r_o_time  <= r_a_desc.ev_time;
            r_o_type  <= r_a_desc.ev_type;
            r_o_blk   <= r_a_desc.is_marker ? r_blk : 8'd0;
            r_o_value <= r_a_desc.is_ts ? {{(24-TICK_W){1'b0}}, quot} : r_a_desc.value;
            r_o_err   <= r_a_desc.is_ts ? (ts_bad ? ERR_TIMESIG : ERR_NONE) : r_a_desc.err;
        end
    end

endmodule

// ===== hdl/mmep_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI meta event parser checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`include "midi_meta_event_parser_core_defines.svh"

module mmep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata
);

    `MMEP_ASSERT(a_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")
    `MMEP_ASSERT(a_status_err, o_m_axis_tvalid && o_m_axis_tdata[73:72] == 2'd1 |-> o_m_axis_tdata[71:32] == 40'd0, "status error carries data")
    `MMEP_ASSERT(a_ts_err, o_m_axis_tvalid && o_m_axis_tdata[73:72] == 2'd2 |-> o_m_axis_tdata[39:32] == 8'd24, "time signature error on wrong event")
    `MMEP_ASSERT(a_pad, o_m_axis_tvalid |-> o_m_axis_tdata[79:74] == 6'd0 && o_m_axis_tdata[73:72] != 2'd3, "bad padding or error code")

endmodule

bind midi_meta_event_parser_core mmep_checker u_mmep_checker (
    .i_clk, .i_rst_n, .o_m_axis_tvalid, .i_m_axis_tready, .o_m_axis_tdata
);

// ===== tb/midi_meta_event_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// MIDI meta event parser core testbench
// Feeds MIDI track bytes, known corner cases from a table first and then
// random well-formed tracks with some noise, while both stream sides idle at
// random outside the last phase. Each event leaving the core is compared with
// a typed table expectation or else a behavioural model of the parser.
// ----------------------------------------------------------------------------
module midi_meta_event_parser_core_tb import mmep_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [7:0]  ev_type;
        logic [7:0]  block;
        logic [23:0] value;
        logic [1:0]  err;
    } t_event;

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       has_exp;
        t_event     exp_ev;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = 5'd1;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;  // [7:0] data_byte
    logic        i_s_axis_tuser = 1'b0;  // [0] track_start
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [31:0] event_time, [39:32] event_kind, [47:40] block_number,
    // [71:48] event_value, [73:72] error_code, [79:74] zero
    logic [79:0] o_m_axis_tdata;

    midi_meta_event_parser_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Parser model state.
    logic [4:0]  cpb;
    t_phase      phase;
    logic [31:0] abs_time, vlq_acc, remaining;
    logic [7:0]  run_status, meta_kind, numerator;
    logic [23:0] field;
    logic [7:0]  loop_count;
    logic        halted;

    t_event pending_events[$];
    int     mismatches = 0;
    int     stall_left = 0;
    bit     no_idle = 1'b0;
    bit     stim_done = 1'b0;

    // Directed rows: expectations are typed in where they are obvious.
    t_row rows[$];

    function automatic bit vlq_shift(input logic [7:0] b);
        vlq_acc = (vlq_acc << 7) | {25'd0, b[6:0]};
        return !b[7];
    endfunction

    function automatic bit two_data(input logic [7:0] st);
        return !(st[7:4] == ST_PROG_HI || st[7:4] == ST_PRES_HI);
    endfunction

    function automatic t_event mk(input logic [7:0] ty, input logic [7:0] blk,
                                  input logic [23:0] val, input logic [1:0] err);
        t_event e;
        e.ev_time = abs_time;
        e.ev_type = ty;
        e.block = blk;
        e.value = val;
        e.err = err;
        return e;
    endfunction

    function automatic bit marker(input logic [7:0] ty, output t_event e);
        e = mk(ty, loop_count, 24'd0, ERR_NONE);
        loop_count = loop_count + 8'd1;
        return 1'b1;
    endfunction

    // Advances the parser model by one byte; returns 1 when an event results.
    function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                      output t_event e);
        logic [31:0] ticks, q, r;
        logic [7:0]  ex;
        e = '0;
        if (start) begin
            abs_time = 0;
            run_status = ST_RESET;
            phase = PH_DELTA;
            vlq_acc = 0;
            remaining = 0;
            halted = 1'b0;
        end
        if (halted) return 1'b0;
        case (phase)
            PH_DELTA: begin
                if (vlq_shift(b)) begin
                    abs_time += vlq_acc;
                    vlq_acc = 0;
                    phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (b < 8'h80) begin
                    phase = two_data(run_status) ? PH_DATA2 : PH_DELTA;
                end else if (b < ST_SYSEX) begin
                    run_status = b;
                    phase = PH_DATA1;
                end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                    phase = PH_SKIPLEN;
                end else if (b == ST_META) begin
                    phase = PH_METATYPE;
                end else begin
                    halted = 1'b1;
                    phase = PH_DELTA;
                    e = mk(EV_NONE, 8'd0, 24'd0, ERR_STATUS);
                    return 1'b1;
                end
            end
            PH_DATA1: phase = two_data(run_status) ? PH_DATA2 : PH_DELTA;
            PH_DATA2: phase = PH_DELTA;
            PH_METATYPE: begin
                meta_kind = b;
                if (b >= 8'd1 && b <= 8'd15) phase = PH_TEXTLEN;
                else if (b == META_EOT || b == META_TEMPO || b == META_TIMESIG)
                    phase = PH_FIXLEN;
                else phase = PH_SKIPLEN;
            end
            PH_FIXLEN: begin
                if (meta_kind == META_EOT) begin
                    phase = PH_DELTA;
                    e = mk(EV_END, 8'd0, 24'd0, ERR_NONE);
                    return 1'b1;
                end
                phase = (meta_kind == META_TEMPO) ? PH_TEMPO0 : PH_TS_NUM;
            end
            PH_TEMPO0: begin
                field = {16'd0, b};
                phase = PH_TEMPO1;
            end
            PH_TEMPO1: begin
                field[15:8] = b;
                phase = PH_TEMPO2;
            end
            PH_TEMPO2: begin
                field[23:16] = b;
                phase = PH_DELTA;
                e = mk(EV_TEMPO, 8'd0, field, ERR_NONE);
                return 1'b1;
            end
            PH_TS_NUM: begin
                numerator = b;
                phase = PH_TS_EXP;
            end
            PH_TS_EXP: begin
                field = {16'd0, b};
                phase = PH_TS_MET;
            end
            PH_TS_MET: phase = PH_TS_32;
            PH_TS_32: begin
                ticks = 32'd96 * numerator * cpb;
                ex = field[7:0];
                if (ex < 8'd32) begin
                    q = ticks >> ex;
                    r = ticks & ((32'd1 << ex) - 32'd1);
                end else begin
                    q = 0;
                    r = ticks;
                end
                phase = PH_DELTA;
                e = mk(EV_TIMESIG, 8'd0, q[23:0],
                       (r != 0 || q == 0 || q >= 32'd65536) ? ERR_TIMESIG : ERR_NONE);
                return 1'b1;
            end
            PH_SKIPLEN, PH_TEXTLEN: begin
                if (vlq_shift(b)) begin
                    remaining = vlq_acc;
                    vlq_acc = 0;
                    if (remaining == 0) phase = PH_DELTA;
                    else phase = (phase == PH_SKIPLEN) ? PH_SKIP : PH_TEXT1;
                end
            end
            PH_SKIP: begin
                remaining--;
                if (remaining == 0) phase = PH_DELTA;
            end
            PH_TEXT1: begin
                remaining--;
                if (b == CH_CLOSE && remaining != 0) begin
                    phase = PH_TEXT2;
                    return 1'b0;
                end
                phase = (remaining == 0) ? PH_DELTA : PH_SKIP;
                if (b == CH_OPEN) return marker(EV_LOOP_BEG, e);
                if (b == CH_COLON) return marker(EV_LOOP_CNT, e);
                if (b == CH_CLOSE) return marker(EV_LOOP_END, e);
            end
            PH_TEXT2: begin
                remaining--;
                phase = (remaining == 0) ? PH_DELTA : PH_SKIP;
                return marker((b == CH_OPEN) ? EV_LOOP_MID : EV_LOOP_END, e);
            end
            default: phase = PH_DELTA;
        endcase
        return 1'b0;
    endfunction

    task automatic idle_burst();
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    // Sends one byte and records the event it should cause.
    task automatic send_byte(input logic [7:0] b, input logic start,
                             input bit has_typed, input t_event typed);
        t_event e;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            idle_burst();
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tuser <= start;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (parse_byte(b, start, e)) begin
            if (has_typed && typed != e)
                $display("model disagrees with table row: %h vs %h", typed, e);
            pending_events.push_back(has_typed ? typed : e);
        end
    endtask

    task automatic send(input logic [7:0] b, input logic start = 1'b0);
        send_byte(b, start, 1'b0, '0);
    endtask

    task automatic send_vlq(input logic [31:0] v);
        logic [7:0] grp[$];
        grp.push_front({1'b0, v[6:0]});
        v >>= 7;
        while (v != 0) begin
            grp.push_front({1'b1, v[6:0]});
            v >>= 7;
        end
        foreach (grp[k]) send(grp[k]);
    endtask

    // Waits for every event, then for the pipeline to drain, then writes.
    task automatic write_cpb(input logic [4:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cpb = val;
    endtask

    // One random event of a well-formed track.
    task automatic send_random_event();
        int kind, n;
        send_vlq(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300));
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1: begin
                send({1'b1, 3'($urandom_range(0, 6)), 4'($urandom())});
                send(8'($urandom_range(0, 127)));
                send(8'($urandom_range(0, 127)));
            end
            2: begin
                send(8'($urandom_range(0, 127)));
                send(8'($urandom_range(0, 127)));
            end
            3: begin
                send($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
                n = $urandom_range(0, 4);
                send_vlq(n);
                repeat (n) send(8'($urandom()));
            end
            4: begin
                send(ST_META); send(META_TEMPO); send(8'd3);
                send(8'($urandom())); send(8'($urandom())); send(8'($urandom()));
            end
            5, 6: begin
                send(ST_META); send(META_TIMESIG); send(8'd4);
                send(8'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 16)));
                send(8'($urandom_range(0, 5) == 0 ? $urandom() : $urandom_range(0, 8)));
                send(8'($urandom())); send(8'($urandom()));
            end
            7, 8, 9: begin
                send(ST_META); send(8'($urandom_range(1, 15)));
                n = $urandom_range(0, 4);
                send_vlq(n);
                for (int k = 0; k < n; k++) begin
                    case ($urandom_range(0, 4))
                        0: send(CH_OPEN);
                        1: send(CH_CLOSE);
                        2: send(CH_COLON);
                        default: send(8'($urandom()));
                    endcase
                end
            end
            10: begin
                send(ST_META); send(8'($urandom_range(16, 255)));
                n = $urandom_range(0, 3);
                send_vlq(n);
                repeat (n) send(8'($urandom()));
            end
            default: begin
                if ($urandom_range(0, 3) == 0) send(8'($urandom_range(8'hF1, 8'hFE)));
                else send(8'($urandom()));
            end
        endcase
    endtask

    task automatic add_row(input logic [7:0] b, input logic s = 1'b0);
        rows.push_back('{b, s, 1'b0, '0});
    endtask

    task automatic add_checked(input logic [7:0] b, input logic [31:0] tm,
                               input logic [7:0] ty, input logic [7:0] blk,
                               input logic [23:0] val, input logic [1:0] err);
        rows.push_back('{b, 1'b0, 1'b1, '{tm, ty, blk, val, err}});
    endtask

    // Result side: stall bursts and comparison against the oldest event.
    always @(posedge i_clk) begin
        t_event got, want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.ev_time = o_m_axis_tdata[31:0];
                got.ev_type = o_m_axis_tdata[39:32];
                got.block   = o_m_axis_tdata[47:40];
                got.value   = o_m_axis_tdata[71:48];
                got.err     = o_m_axis_tdata[73:72];
                if (pending_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected event %h", got);
                end else begin
                    want = pending_events.pop_front();
                    if (got != want || o_m_axis_tdata[79:74] != 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("event mismatch: expected t=%h ty=%h blk=%h v=%h e=%h, got t=%h ty=%h blk=%h v=%h e=%h",
                                     want.ev_time, want.ev_type, want.block, want.value, want.err,
                                     got.ev_time, got.ev_type, got.block, got.value, got.err);
                    end
                end
            end
            if (!no_idle && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 3);
            if (!no_idle && stall_left != 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int n;
        cpb = 5'd1; phase = PH_DELTA; abs_time = 0; vlq_acc = 0; remaining = 0;
        run_status = ST_RESET; meta_kind = 0; numerator = 0; field = 0;
        loop_count = 0; halted = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, the fixed-length meta kinds, text marker cases, bad status.
        add_row(8'h00, 1'b1); add_row(ST_META); add_row(META_EOT);
        add_checked(8'h00, 32'd0, EV_END, 8'd0, 24'd0, ERR_NONE);
        add_row(8'h81); add_row(8'h00); add_row(ST_META); add_row(META_TEMPO);
        add_row(8'h03); add_row(8'h20); add_row(8'hA1);
        add_checked(8'h07, 32'd128, EV_TEMPO, 8'd0, 24'h07A120, ERR_NONE);
        add_row(8'h00); add_row(ST_META); add_row(META_TIMESIG); add_row(8'h04);
        add_row(8'h04); add_row(8'h02); add_row(8'h18);
        add_checked(8'h08, 32'd128, EV_TIMESIG, 8'd0, 24'd96, ERR_NONE);
        add_row(8'h00); add_row(ST_META); add_row(8'h06); add_row(8'h01);
        add_checked(CH_CLOSE, 32'd128, EV_LOOP_END, 8'd0, 24'd0, ERR_NONE);
        add_row(8'h00); add_row(ST_META); add_row(8'h01); add_row(8'h00);
        add_row(8'h00);
        add_checked(8'hF4, 32'd128, EV_NONE, 8'd0, 24'd0, ERR_STATUS);
        add_row(8'hFF);
        foreach (rows[k])
            send_byte(rows[k].data, rows[k].start, rows[k].has_exp, rows[k].exp_ev);

        // Phases over clocks_per_beat settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_cpb(5'd16);
                1: write_cpb(5'd1);
                5: write_cpb(5'd31);
                default: write_cpb(5'($urandom_range(1, 16)));
            endcase
            if (ph == 5) no_idle = 1'b1;
            send(8'h00, 1'b1);
            n = 0;
            // Tracks of random events; the start byte begins a delta.
            send(ST_META); send(META_EOT); send(8'h00);
            while (n < 300) begin
                send_random_event();
                n += 6;
                if ($urandom_range(0, 30) == 0) begin
                    send(8'($urandom_range(0, 127)), 1'b1);
                    send_random_event();
                end
            end
            send_vlq(0); send(ST_META); send(META_TIMESIG); send(8'h04);
            send(8'hFF); send(8'h00); send(8'h00); send(8'h00);
            send_vlq(32'hFFFF_FFFF); send(8'h90); send(8'h7F); send(8'h7F);
            send(8'h00, 1'b1);
        end
        i_s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
